[design/tak_pkg.sv]
// Shared types, constants and saturation helpers for the tilt angle filter.
// Used by the multiplier, the divider and the sequencer at the top level.
`default_nettype none

package tak_pkg;

    localparam int VALUE_FRAC_BITS = 16;
    localparam int COV_FRAC_BITS   = 44;

    localparam int VAL_W     = 32;
    localparam int COV_W     = 48;
    localparam int OP_W      = 56;
    localparam int HALF_W    = OP_W / 2;
    localparam int PROD_W    = 2 * OP_W;
    localparam int SUM_W     = 50;
    localparam int CFG_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int TS_W      = 24;
    localparam int GAIN_W    = 24;
    localparam int SAMPLE_W  = 16;
    localparam int GSCALE_W  = 28;
    localparam int NOISE_W   = 40;

    localparam int ACCEL_SHIFT     = 12;
    localparam int TIME_SHIFT      = 24;
    localparam int RATE_SHIFT      = 31 - VALUE_FRAC_BITS;
    localparam int GYRO_FULL_SCALE = 2000;

    localparam logic [TS_W-1:0]           TIME_STEP_RST = 24'd124151;
    localparam logic [NOISE_W-1:0]        ANGLE_NOISE_RST = 40'd8796093022;
    localparam logic [NOISE_W-1:0]        BIAS_NOISE_RST = 40'd52776558;
    localparam logic [NOISE_W-1:0]        MEAS_NOISE_RST = 40'd351843720888;
    localparam logic signed [GAIN_W-1:0]  GYRO_GAIN_RST = 24'sd65536;

    localparam logic signed [COV_W-1:0] COV_ONE =
        (COV_FRAC_BITS >= COV_W - 1) ? {1'b0, {(COV_W-1){1'b1}}}
                                     : COV_W'(64'd1 << COV_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP,
        CFG_ANGLE_NOISE,
        CFG_BIAS_NOISE,
        CFG_MEASURE_NOISE,
        CFG_GYRO_GAIN
    } cfg_index_t;

    typedef enum logic [1:0] {
        SH_ACCEL,
        SH_RATE,
        SH_TIME,
        SH_COV
    } mul_shift_t;

    typedef struct packed {
        logic                   start;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
        mul_shift_t             sh;
        logic                   wide;
    } mul_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [COV_W-1:0] num;
        logic [COV_W-1:0]        den;
    } div_req_t;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_PROD,
        MUL_ROUND,
        MUL_SAT
    } mul_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_ROUND,
        DIV_SAT
    } div_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAS,
        ST_RATE,
        ST_ANG,
        ST_PAA,
        ST_PAB,
        ST_PBB,
        ST_DIV0,
        ST_DIV1,
        ST_CAA,
        ST_CAB,
        ST_CBA,
        ST_CBB,
        ST_CANG,
        ST_CBIAS,
        ST_OUT
    } seq_state_t;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
        logic fits;
        fits = (&x[SUM_W-1:VAL_W-1]) || !(|x[SUM_W-1:VAL_W-1]);
        return fits ? x[VAL_W-1:0] : {x[SUM_W-1], {(VAL_W-1){~x[SUM_W-1]}}};
    endfunction

    function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [SUM_W-1:0] x);
        logic fits;
        fits = (&x[SUM_W-1:COV_W-1]) || !(|x[SUM_W-1:COV_W-1]);
        return fits ? x[COV_W-1:0] : {x[SUM_W-1], {(COV_W-1){~x[SUM_W-1]}}};
    endfunction

endpackage

`default_nettype wire

[design/tak_mul.sv]
// Shared multiply unit: sign-magnitude product from four half-width partial
// products, then round to nearest and saturate. Depends on tak_pkg.
`default_nettype none

module tak_mul (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire tak_pkg::mul_req_t               req,
    output logic                                 done,
    output logic signed [tak_pkg::COV_W-1:0]     result
);

    localparam int OP_W   = tak_pkg::OP_W;
    localparam int HALF_W = tak_pkg::HALF_W;
    localparam int PROD_W = tak_pkg::PROD_W;
    localparam int COV_W  = tak_pkg::COV_W;
    localparam int VAL_W  = tak_pkg::VAL_W;
    localparam logic [1:0] PART_LAST = 2'b11;

    tak_pkg::mul_state_t state_reg, state_next;
    logic [OP_W-1:0]     ma_reg, ma_next, mb_reg, mb_next;
    logic                neg_reg, neg_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [1:0]          cnt_reg, cnt_next;
    tak_pkg::mul_shift_t sh_reg, sh_next;
    logic                wide_reg, wide_next;
    logic                done_reg, done_next;
    logic signed [COV_W-1:0] res_reg, res_next;

    logic [HALF_W-1:0] half_a, half_b;
    logic [OP_W-1:0]   pp;
    logic [PROD_W-1:0] pp_pos, w_lim, sat_mag;
    logic              over;
    logic [COV_W-1:0]  mag48;

    function automatic logic [PROD_W-1:0] round_shift(input logic [PROD_W-1:0] x,
                                                      input int n);
        return (x + (PROD_W'(1) << (n - 1))) >> n;
    endfunction

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tak_pkg::MUL_IDLE:  if (req.start) state_next = tak_pkg::MUL_PROD;
            tak_pkg::MUL_PROD:  if (cnt_reg == PART_LAST) state_next = tak_pkg::MUL_ROUND;
            tak_pkg::MUL_ROUND: state_next = tak_pkg::MUL_SAT;
            tak_pkg::MUL_SAT:   state_next = tak_pkg::MUL_IDLE;
            default:            state_next = tak_pkg::MUL_IDLE;
        endcase
    end

    always_comb begin
        half_a = cnt_reg[1] ? ma_reg[OP_W-1:HALF_W] : ma_reg[HALF_W-1:0];
        half_b = cnt_reg[0] ? mb_reg[OP_W-1:HALF_W] : mb_reg[HALF_W-1:0];
        pp     = half_a * half_b;
        case (cnt_reg)
            2'b00:   pp_pos = PROD_W'(pp);
            2'b11:   pp_pos = PROD_W'(pp) << OP_W;
            default: pp_pos = PROD_W'(pp) << HALF_W;
        endcase

        w_lim   = wide_reg ? (PROD_W'(1) << (COV_W - 1)) : (PROD_W'(1) << (VAL_W - 1));
        over    = neg_reg ? (acc_reg > w_lim) : (acc_reg >= w_lim);
        sat_mag = over ? (neg_reg ? w_lim : w_lim - PROD_W'(1)) : acc_reg;
        mag48   = sat_mag[COV_W-1:0];
    end

    always_comb begin
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        wide_next = wide_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        case (state_reg)
            tak_pkg::MUL_IDLE: begin
                if (req.start) begin
                    ma_next   = req.a[OP_W-1] ? OP_W'(-req.a) : OP_W'(req.a);
                    mb_next   = req.b[OP_W-1] ? OP_W'(-req.b) : OP_W'(req.b);
                    neg_next  = req.a[OP_W-1] ^ req.b[OP_W-1];
                    acc_next  = '0;
                    cnt_next  = '0;
                    sh_next   = req.sh;
                    wide_next = req.wide;
                end
            end
            tak_pkg::MUL_PROD: begin
                acc_next = acc_reg + pp_pos;
                cnt_next = cnt_reg + 2'd1;
            end
            tak_pkg::MUL_ROUND: begin
                case (sh_reg)
                    tak_pkg::SH_ACCEL: acc_next = round_shift(acc_reg, tak_pkg::ACCEL_SHIFT);
                    tak_pkg::SH_RATE:  acc_next = round_shift(acc_reg, tak_pkg::RATE_SHIFT);
                    tak_pkg::SH_TIME:  acc_next = round_shift(acc_reg, tak_pkg::TIME_SHIFT);
                    default:           acc_next = round_shift(acc_reg, tak_pkg::COV_FRAC_BITS);
                endcase
            end
            tak_pkg::MUL_SAT: begin
                res_next  = neg_reg ? $signed(-mag48) : $signed(mag48);
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tak_pkg::MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        sh_reg   <= sh_next;
        wide_reg <= wide_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[design/tak_div.sv]
// Restoring divider, one quotient bit per cycle: round(num * 2^CF / den)
// with ties away from zero, saturated to the covariance width. Uses tak_pkg.
`default_nettype none

module tak_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire tak_pkg::div_req_t               req,
    output logic                                 done,
    output logic signed [tak_pkg::COV_W-1:0]     result
);

    localparam int COV_W = tak_pkg::COV_W;
    localparam int NUM_W = COV_W + tak_pkg::COV_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    tak_pkg::div_state_t state_reg, state_next;
    logic [NUM_W-1:0] num_reg, num_next, quo_reg, quo_next;
    logic [COV_W:0]   rem_reg, rem_next;
    logic [COV_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic signed [COV_W-1:0] res_reg, res_next;

    logic [COV_W:0]   trial;
    logic             ge;
    logic [COV_W-1:0] num_mag;
    logic [NUM_W-1:0] lim, sat_q;
    logic             over;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tak_pkg::DIV_IDLE:  if (req.start) state_next = tak_pkg::DIV_RUN;
            tak_pkg::DIV_RUN:   if (cnt_reg == CNT_W'(1)) state_next = tak_pkg::DIV_ROUND;
            tak_pkg::DIV_ROUND: state_next = tak_pkg::DIV_SAT;
            tak_pkg::DIV_SAT:   state_next = tak_pkg::DIV_IDLE;
            default:            state_next = tak_pkg::DIV_IDLE;
        endcase
    end

    always_comb begin
        num_mag = req.num[COV_W-1] ? COV_W'(-req.num) : COV_W'(req.num);
        trial   = {rem_reg[COV_W-1:0], num_reg[NUM_W-1]};
        ge      = trial >= {1'b0, den_reg};
        lim     = NUM_W'(1) << (COV_W - 1);
        over    = neg_reg ? (quo_reg > lim) : (quo_reg >= lim);
        sat_q   = over ? (neg_reg ? lim : lim - NUM_W'(1)) : quo_reg;
    end

    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        case (state_reg)
            tak_pkg::DIV_IDLE: begin
                if (req.start) begin
                    num_next = NUM_W'(num_mag) << tak_pkg::COV_FRAC_BITS;
                    quo_next = '0;
                    rem_next = '0;
                    den_next = req.den;
                    neg_next = req.num[COV_W-1];
                    cnt_next = CNT_W'(NUM_W);
                end
            end
            tak_pkg::DIV_RUN: begin
                rem_next = ge ? trial - {1'b0, den_reg} : trial;
                quo_next = {quo_reg[NUM_W-2:0], ge};
                num_next = num_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            tak_pkg::DIV_ROUND: begin
                // round half up on the remainder
                if ({rem_reg, 1'b0} >= {2'b00, den_reg}) quo_next = quo_reg + NUM_W'(1);
            end
            tak_pkg::DIV_SAT: begin
                res_next  = neg_reg ? $signed(-sat_q[COV_W-1:0]) : $signed(sat_q[COV_W-1:0]);
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tak_pkg::DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

[design/tilt_angle_kalman_fusion.sv]
// Tilt angle filter, two states (angle, gyro bias): one sample in, one result out.
// Each sample passes through twelve multiplies on the shared multiplier and, when the
// innovation is positive, two gain divisions on the one-bit-per-cycle divider.
// s_ready is low while a sample is worked on; one sample is taken at a time.
// Synchronous active-low reset restores register defaults, zero angle and bias,
// and unit diagonal covariance. Depends on tak_pkg, tak_mul and tak_div.
`default_nettype none

module tilt_angle_kalman_fusion (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tak_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tak_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [tak_pkg::SAMPLE_W-1:0] s_accel_z,
    input  wire logic signed [tak_pkg::SAMPLE_W-1:0] s_gyro_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [tak_pkg::VAL_W-1:0]         m_angle_est,
    output logic signed [tak_pkg::VAL_W-1:0]         m_rate_est
);

    localparam int VAL_W    = tak_pkg::VAL_W;
    localparam int COV_W    = tak_pkg::COV_W;
    localparam int OP_W     = tak_pkg::OP_W;
    localparam int SUM_W    = tak_pkg::SUM_W;
    localparam int TS_W     = tak_pkg::TS_W;
    localparam int GAIN_W   = tak_pkg::GAIN_W;
    localparam int NOISE_W  = tak_pkg::NOISE_W;
    localparam int SAMPLE_W = tak_pkg::SAMPLE_W;
    localparam int GSCALE_W = tak_pkg::GSCALE_W;
    localparam logic signed [OP_W-1:0] ACCEL_SCALE = OP_W'(1) << tak_pkg::VALUE_FRAC_BITS;

    // configuration
    logic [TS_W-1:0]          ts_reg;
    logic [NOISE_W-1:0]       apn_reg, bpn_reg, mn_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    tak_pkg::seq_state_t state_reg, state_next;
    logic issued_reg;
    logic signed [SAMPLE_W-1:0] accel_reg, gyro_reg;
    logic signed [VAL_W-1:0] meas_reg, rate_reg, angle_reg, bias_reg;
    logic signed [COV_W-1:0] caa_reg, cab_reg, cba_reg, cbb_reg, t0_reg, t1_reg;
    logic signed [COV_W-1:0] k0_reg, k1_reg;
    logic signed [VAL_W:0]   err_reg;
    logic m_valid_reg;
    logic signed [VAL_W-1:0] out_angle_reg, out_rate_reg;

    tak_pkg::mul_req_t mul_req;
    tak_pkg::div_req_t div_req;
    logic mul_done, div_done;
    logic signed [COV_W-1:0] mul_res, div_res;

    logic signed [GSCALE_W-1:0] gyro_scaled;
    logic signed [SUM_W-1:0]    innov;
    logic                       innov_pos;
    logic signed [VAL_W:0]      err_now;
    logic signed [OP_W-1:0]     dt_op;
    logic                       out_free;
    logic                       is_mul_state;

    tak_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .result  (mul_res)
    );

    tak_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .result  (div_res)
    );

    assign gyro_scaled = GSCALE_W'(gyro_reg) * GSCALE_W'(tak_pkg::GYRO_FULL_SCALE);
    assign innov       = SUM_W'($signed({1'b0, mn_reg})) + SUM_W'(caa_reg);
    assign innov_pos   = !innov[SUM_W-1] && (innov != '0);
    assign err_now     = (VAL_W+1)'(meas_reg) - (VAL_W+1)'(angle_reg);
    assign dt_op       = OP_W'($signed({1'b0, ts_reg}));
    assign out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg   <= tak_pkg::TIME_STEP_RST;
            apn_reg  <= tak_pkg::ANGLE_NOISE_RST;
            bpn_reg  <= tak_pkg::BIAS_NOISE_RST;
            mn_reg   <= tak_pkg::MEAS_NOISE_RST;
            gain_reg <= tak_pkg::GYRO_GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tak_pkg::CFG_TIME_STEP:     ts_reg   <= cfg_wdata[TS_W-1:0];
                tak_pkg::CFG_ANGLE_NOISE:   apn_reg  <= cfg_wdata[NOISE_W-1:0];
                tak_pkg::CFG_BIAS_NOISE:    bpn_reg  <= cfg_wdata[NOISE_W-1:0];
                tak_pkg::CFG_MEASURE_NOISE: mn_reg   <= cfg_wdata[NOISE_W-1:0];
                tak_pkg::CFG_GYRO_GAIN:     gain_reg <= $signed(cfg_wdata[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tak_pkg::ST_IDLE:  if (s_valid) state_next = tak_pkg::ST_MEAS;
            tak_pkg::ST_MEAS:  if (mul_done) state_next = tak_pkg::ST_RATE;
            tak_pkg::ST_RATE:  if (mul_done) state_next = tak_pkg::ST_ANG;
            tak_pkg::ST_ANG:   if (mul_done) state_next = tak_pkg::ST_PAA;
            tak_pkg::ST_PAA:   if (mul_done) state_next = tak_pkg::ST_PAB;
            tak_pkg::ST_PAB:   if (mul_done) state_next = tak_pkg::ST_PBB;
            tak_pkg::ST_PBB: begin
                if (mul_done) state_next = innov_pos ? tak_pkg::ST_DIV0 : tak_pkg::ST_CAA;
            end
            tak_pkg::ST_DIV0:  if (div_done) state_next = tak_pkg::ST_DIV1;
            tak_pkg::ST_DIV1:  if (div_done) state_next = tak_pkg::ST_CAA;
            tak_pkg::ST_CAA:   if (mul_done) state_next = tak_pkg::ST_CAB;
            tak_pkg::ST_CAB:   if (mul_done) state_next = tak_pkg::ST_CBA;
            tak_pkg::ST_CBA:   if (mul_done) state_next = tak_pkg::ST_CBB;
            tak_pkg::ST_CBB:   if (mul_done) state_next = tak_pkg::ST_CANG;
            tak_pkg::ST_CANG:  if (mul_done) state_next = tak_pkg::ST_CBIAS;
            tak_pkg::ST_CBIAS: if (mul_done) state_next = tak_pkg::ST_OUT;
            tak_pkg::ST_OUT:   if (out_free) state_next = tak_pkg::ST_IDLE;
            default:           state_next = tak_pkg::ST_IDLE;
        endcase
    end

    // operand selection for the shared units
    always_comb begin
        is_mul_state = 1'b1;
        mul_req      = '0;
        mul_req.sh   = tak_pkg::SH_TIME;
        mul_req.wide = 1'b1;
        div_req      = '0;
        case (state_reg)
            tak_pkg::ST_MEAS: begin
                mul_req.a    = -OP_W'(accel_reg);
                mul_req.b    = ACCEL_SCALE;
                mul_req.sh   = tak_pkg::SH_ACCEL;
                mul_req.wide = 1'b0;
            end
            tak_pkg::ST_RATE: begin
                mul_req.a    = -OP_W'(gyro_scaled);
                mul_req.b    = OP_W'(gain_reg);
                mul_req.sh   = tak_pkg::SH_RATE;
                mul_req.wide = 1'b0;
            end
            tak_pkg::ST_ANG: begin
                mul_req.a    = OP_W'(rate_reg) - OP_W'(bias_reg);
                mul_req.b    = dt_op;
                mul_req.wide = 1'b0;
            end
            tak_pkg::ST_PAA: begin
                mul_req.a = OP_W'($signed({1'b0, apn_reg})) - OP_W'(cab_reg) - OP_W'(cba_reg);
                mul_req.b = dt_op;
            end
            tak_pkg::ST_PAB: begin
                mul_req.a = -OP_W'(cbb_reg);
                mul_req.b = dt_op;
            end
            tak_pkg::ST_PBB: begin
                mul_req.a = OP_W'($signed({1'b0, bpn_reg}));
                mul_req.b = dt_op;
            end
            tak_pkg::ST_CAA: begin
                mul_req.a  = OP_W'(k0_reg);
                mul_req.b  = OP_W'(t0_reg);
                mul_req.sh = tak_pkg::SH_COV;
            end
            tak_pkg::ST_CAB: begin
                mul_req.a  = OP_W'(k0_reg);
                mul_req.b  = OP_W'(t1_reg);
                mul_req.sh = tak_pkg::SH_COV;
            end
            tak_pkg::ST_CBA: begin
                mul_req.a  = OP_W'(k1_reg);
                mul_req.b  = OP_W'(t0_reg);
                mul_req.sh = tak_pkg::SH_COV;
            end
            tak_pkg::ST_CBB: begin
                mul_req.a  = OP_W'(k1_reg);
                mul_req.b  = OP_W'(t1_reg);
                mul_req.sh = tak_pkg::SH_COV;
            end
            tak_pkg::ST_CANG: begin
                mul_req.a    = OP_W'(k0_reg);
                mul_req.b    = OP_W'(err_reg);
                mul_req.sh   = tak_pkg::SH_COV;
                mul_req.wide = 1'b0;
            end
            tak_pkg::ST_CBIAS: begin
                mul_req.a    = OP_W'(k1_reg);
                mul_req.b    = OP_W'(err_reg);
                mul_req.sh   = tak_pkg::SH_COV;
                mul_req.wide = 1'b0;
            end
            tak_pkg::ST_DIV0: begin
                is_mul_state  = 1'b0;
                div_req.start = !issued_reg;
                div_req.num   = t0_reg;
                div_req.den   = innov[COV_W-1:0];
            end
            tak_pkg::ST_DIV1: begin
                is_mul_state  = 1'b0;
                div_req.start = !issued_reg;
                div_req.num   = cba_reg;
                div_req.den   = innov[COV_W-1:0];
            end
            default: is_mul_state = 1'b0;
        endcase
        mul_req.start = is_mul_state && !issued_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tak_pkg::ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            angle_reg   <= '0;
            bias_reg    <= '0;
            caa_reg     <= tak_pkg::COV_ONE;
            cab_reg     <= '0;
            cba_reg     <= '0;
            cbb_reg     <= tak_pkg::COV_ONE;
        end else begin
            state_reg <= state_next;
            if (mul_done || div_done) issued_reg <= 1'b0;
            else if (mul_req.start || div_req.start) issued_reg <= 1'b1;

            if (state_reg == tak_pkg::ST_OUT && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            if (mul_done) begin
                case (state_reg)
                    tak_pkg::ST_ANG:
                        angle_reg <= tak_pkg::sat_val(SUM_W'(angle_reg) + SUM_W'(mul_res));
                    tak_pkg::ST_PAA:
                        caa_reg <= tak_pkg::sat_cov(SUM_W'(caa_reg) + SUM_W'(mul_res));
                    tak_pkg::ST_PAB: begin
                        cab_reg <= tak_pkg::sat_cov(SUM_W'(cab_reg) + SUM_W'(mul_res));
                        cba_reg <= tak_pkg::sat_cov(SUM_W'(cba_reg) + SUM_W'(mul_res));
                    end
                    tak_pkg::ST_PBB:
                        cbb_reg <= tak_pkg::sat_cov(SUM_W'(cbb_reg) + SUM_W'(mul_res));
                    tak_pkg::ST_CAA:
                        caa_reg <= tak_pkg::sat_cov(SUM_W'(caa_reg) - SUM_W'(mul_res));
                    tak_pkg::ST_CAB:
                        cab_reg <= tak_pkg::sat_cov(SUM_W'(cab_reg) - SUM_W'(mul_res));
                    tak_pkg::ST_CBA:
                        cba_reg <= tak_pkg::sat_cov(SUM_W'(cba_reg) - SUM_W'(mul_res));
                    tak_pkg::ST_CBB:
                        cbb_reg <= tak_pkg::sat_cov(SUM_W'(cbb_reg) - SUM_W'(mul_res));
                    tak_pkg::ST_CANG:
                        angle_reg <= tak_pkg::sat_val(SUM_W'(angle_reg) + SUM_W'(mul_res));
                    tak_pkg::ST_CBIAS:
                        bias_reg <= tak_pkg::sat_val(SUM_W'(bias_reg) + SUM_W'(mul_res));
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == tak_pkg::ST_IDLE && s_valid) begin
            accel_reg <= s_accel_z;
            gyro_reg  <= s_gyro_y;
        end
        if (mul_done) begin
            case (state_reg)
                tak_pkg::ST_MEAS: meas_reg <= mul_res[VAL_W-1:0];
                tak_pkg::ST_RATE: rate_reg <= mul_res[VAL_W-1:0];
                tak_pkg::ST_PBB: begin
                    // latch the predicted terms used by the whole correction
                    t0_reg  <= caa_reg;
                    t1_reg  <= cab_reg;
                    err_reg <= err_now;
                    if (!innov_pos) begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
        if (div_done) begin
            if (state_reg == tak_pkg::ST_DIV0) k0_reg <= div_res;
            else k1_reg <= div_res;
        end
        if (state_reg == tak_pkg::ST_OUT && out_free) begin
            out_angle_reg <= angle_reg;
            out_rate_reg  <= tak_pkg::sat_val(SUM_W'(rate_reg) - SUM_W'(bias_reg));
        end
    end

    assign s_ready     = (state_reg == tak_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_angle_est = out_angle_reg;
    assign m_rate_est  = out_rate_reg;

endmodule

`default_nettype wire

[design/tak_checker.sv]
// Port-level checks for the tilt angle filter, bound to the top level.
// Depends on tak_pkg for widths.
`default_nettype none

module tak_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [tak_pkg::VAL_W-1:0]    m_angle_est,
    input wire logic signed [tak_pkg::VAL_W-1:0]    m_rate_est
);

    // block comes out of reset idle with nothing to deliver
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> s_ready && !m_valid)
        else $error("not idle after reset");

    // one sample at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_angle_est) && $stable(m_rate_est))
        else $error("result changed while stalled");

endmodule

bind tilt_angle_kalman_fusion tak_checker u_tak_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_angle_est (m_angle_est),
    .m_rate_est  (m_rate_est)
);

`default_nettype wire
